>>> rtl/rcsfr_pkg.sv
`default_nettype none

package rcsfr_pkg;

    // Frame layout.
    localparam int FRAME_BYTES = 32;
    localparam int POS_W       = 5;
    localparam logic [POS_W-1:0] POS_HUNT   = 5'd0;
    localparam logic [POS_W-1:0] POS_CH0    = 5'd2;
    localparam logic [POS_W-1:0] POS_CHK_LO = 5'd30;
    localparam logic [POS_W-1:0] POS_LAST   = 5'd31;

    // Field widths.
    localparam int BYTE_W   = 8;
    localparam int TIME_W   = 32;
    localparam int VAL_W    = 16;
    localparam int CH_IDX_W = 4;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    localparam logic [VAL_W-1:0] CHK_INIT = 16'hFFFF;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LIMIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK      = 2'd3;

    localparam logic [15:0]       RST_GAP_THRESHOLD = 16'd3000;
    localparam logic [BYTE_W-1:0] RST_SYNC_BYTE     = 8'h20;
    localparam logic [VAL_W-1:0]  RST_VALUE_LIMIT   = 16'd2100;
    localparam logic [VAL_W-1:0]  RST_FALLBACK      = 16'd1000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_in;
        logic process;
        logic load_first;
        logic load_err;
        logic load_next;
        logic clr_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_end;
        logic frame_ok;
        logic out_last;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> rtl/rcsfr_ctrl.sv
`default_nettype none

module rcsfr_ctrl
    import rcsfr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire logic    i_out_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PROC = 3'b010,
        ST_SEND = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = ST_PROC;
                end
            end
            ST_PROC: begin
                o_cmd.process = 1'b1;
                if (i_sts.frame_end) begin
                    o_cmd.load_first = i_sts.frame_ok;
                    o_cmd.load_err   = !i_sts.frame_ok;
                    n_state          = ST_SEND;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SEND: begin
                if (i_out_ready) begin
                    if (i_sts.out_last) begin
                        o_cmd.clr_out = 1'b1;
                        n_state       = ST_IDLE;
                    end else begin
                        o_cmd.load_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/rcsfr_dp.sv
`default_nettype none

module rcsfr_dp
    import rcsfr_pkg::*;
#(
    parameter int NUM_CHANNELS = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic [BYTE_W-1:0]     i_rx_byte,
    input  wire logic [TIME_W-1:0]     i_arrival_time,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_sts                    o_sts,
    output logic                       o_out_valid,
    output logic                       o_out_status,
    output logic [CH_IDX_W-1:0]        o_out_index,
    output logic [VAL_W-1:0]           o_out_value,
    output logic                       o_out_last
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NUM_CHANNELS - 1);
    localparam logic [POS_W-1:0]    POS_CH_END = POS_W'(2 + 2 * NUM_CHANNELS);

    // Configuration registers.
    logic [15:0]       r_gap_thr;
    logic [BYTE_W-1:0] r_sync;
    logic [VAL_W-1:0]  r_limit;
    logic [VAL_W-1:0]  r_fallback;

    // Frame state.
    logic [POS_W-1:0]  r_pos;
    logic [TIME_W-1:0] r_last_time;
    logic [VAL_W-1:0]  r_chk;
    logic [BYTE_W-1:0] r_chk_lo;
    logic [VAL_W-1:0]  r_store [NUM_CHANNELS];

    // Input item held for processing.
    logic [BYTE_W-1:0] r_byte;
    logic [TIME_W-1:0] r_time;

    // Output register.
    logic                r_out_valid;
    logic                r_out_status;
    logic [CH_IDX_W-1:0] r_out_index;
    logic [VAL_W-1:0]    r_out_value;

    logic [TIME_W-1:0]   gap;
    logic [POS_W-1:0]    pos_eff;
    logic                drop;
    logic [POS_W-1:0]    ch_off;
    logic [POS_W-2:0]    ch_sel;
    logic [CH_IDX_W-1:0] rd_idx;
    logic [VAL_W-1:0]    rd_word;
    logic [VAL_W-1:0]    rd_val;
    logic                out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_thr  <= RST_GAP_THRESHOLD;
            r_sync     <= RST_SYNC_BYTE;
            r_limit    <= RST_VALUE_LIMIT;
            r_fallback <= RST_FALLBACK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAP_THRESHOLD: r_gap_thr  <= i_cfg_wdata;
                CFG_SYNC_BYTE:     r_sync     <= i_cfg_wdata[BYTE_W-1:0];
                CFG_VALUE_LIMIT:   r_limit    <= i_cfg_wdata;
                CFG_FALLBACK:      r_fallback <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // A gap strictly longer than the threshold restarts the frame.
    assign gap     = r_time - r_last_time;
    assign pos_eff = (gap > TIME_W'(r_gap_thr)) ? POS_HUNT : r_pos;
    assign drop    = (pos_eff == POS_HUNT) && (r_byte != r_sync);
    assign ch_off  = pos_eff - POS_CH0;
    assign ch_sel  = ch_off[POS_W-1:1];

    // The result on offer is the last of its frame.
    assign out_last = r_out_status || (r_out_index == LAST_CH);

    assign o_sts.frame_end = (pos_eff == POS_LAST);
    assign o_sts.frame_ok  = ({r_byte, r_chk_lo} == r_chk);
    assign o_sts.out_last  = out_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_byte <= i_rx_byte;
            r_time <= i_arrival_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_HUNT;
            r_last_time <= '0;
            r_chk       <= CHK_INIT;
        end else if (i_cmd.process) begin
            r_last_time <= r_time;
            if (drop || (pos_eff == POS_LAST)) begin
                r_pos <= POS_HUNT;
            end else begin
                r_pos <= pos_eff + POS_W'(1);
            end
            if (!drop) begin
                if (pos_eff == POS_HUNT) begin
                    r_chk <= CHK_INIT - VAL_W'(r_byte);
                end else if (pos_eff < POS_CHK_LO) begin
                    r_chk <= r_chk - VAL_W'(r_byte);
                end
            end
        end
    end

    // Channel words and the checksum low byte need no reset: each is written
    // inside the frame before the final byte reads it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.process && !drop) begin
            if (pos_eff >= POS_CH0 && pos_eff < POS_CH_END) begin
                if (ch_off[0]) begin
                    r_store[ch_sel[CH_W-1:0]][VAL_W-1:BYTE_W] <= r_byte;
                end else begin
                    r_store[ch_sel[CH_W-1:0]][BYTE_W-1:0] <= r_byte;
                end
            end
            if (pos_eff == POS_CHK_LO) begin
                r_chk_lo <= r_byte;
            end
        end
    end

    // Channel read for the next result.
    assign rd_idx  = i_cmd.load_first ? '0 : r_out_index + CH_IDX_W'(1);
    assign rd_word = r_store[rd_idx[CH_W-1:0]];
    assign rd_val  = (rd_word > r_limit) ? r_fallback : rd_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_first || i_cmd.load_next || i_cmd.load_err) begin
            r_out_valid <= 1'b1;
        end else if (i_cmd.clr_out) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_err) begin
            r_out_status <= 1'b1;
            r_out_index  <= '0;
            r_out_value  <= '0;
        end else if (i_cmd.load_first || i_cmd.load_next) begin
            r_out_status <= 1'b0;
            r_out_index  <= rd_idx;
            r_out_value  <= rd_val;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_index  = r_out_index;
    assign o_out_value  = r_out_value;
    assign o_out_last   = out_last;

endmodule

`default_nettype wire

>>> rtl/rc_serial_frame_receiver.sv
// Each byte is taken in the idle state and then processed in the processing state;
// the first result of a frame is loaded as the processing of its last byte ends.
// Throughput: no byte is taken while one is processed; a good frame then sends
// NUM_CHANNELS results and a bad one a single result, one per cycle while the sink is
// ready, and the input waits until the last of them has gone. Reset: synchronous,
// active low; the registers take their defaults and the receiver hunts for the sync byte.
`default_nettype none

module rc_serial_frame_receiver
    import rcsfr_pkg::*;
#(
    parameter int NUM_CHANNELS = 10
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    // Configuration writes, one register per cycle.
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,

    // Received bytes.
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata, lowest bits first: rx_byte[7:0], arrival_time_us[39:8].
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,

    // Decoded results.
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata, lowest bits first: channel_index[3:0], channel_value[19:4],
    // zero fill[23:20].
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // tuser: frame_status (high on a checksum mismatch).
    output logic                        m_axis_tuser,
    output logic                        m_axis_tlast
);

    // The controller sequences each byte through the idle state, where it is taken,
    // and the processing state, and after the last byte of a frame walks the result
    // transfers; the datapath holds the configuration, frame position, checksum,
    // channel words and the output register.
    t_dp_cmd             cmd;
    t_dp_sts             sts;
    logic [CH_IDX_W-1:0] out_index;
    logic [VAL_W-1:0]    out_value;

    rcsfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rcsfr_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_rx_byte      (s_axis_tdata[BYTE_W-1:0]),
        .i_arrival_time (s_axis_tdata[BYTE_W+TIME_W-1:BYTE_W]),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (m_axis_tvalid),
        .o_out_status   (m_axis_tuser),
        .o_out_index    (out_index),
        .o_out_value    (out_value),
        .o_out_last     (m_axis_tlast)
    );

    // Pack the result word; the top nibble is fill.
    assign m_axis_tdata = {{(OUT_TDATA_W - CH_IDX_W - VAL_W){1'b0}}, out_value, out_index};

endmodule

`default_nettype wire

>>> rtl/rcsfr_checker.sv
`default_nettype none

module rcsfr_checker
    import rcsfr_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tuser,
    input wire logic                   m_axis_tlast
);

    // No new byte is taken while a result is still on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // An error result is the only one of its frame and carries zero data.
    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == '0)))
        else $error("malformed error result");

    // A non-final channel result is followed by the next channel index.
    a_ch_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && !m_axis_tuser &&
         (m_axis_tdata[CH_IDX_W-1:0] ==
          $past(m_axis_tdata[CH_IDX_W-1:0]) + CH_IDX_W'(1))))
        else $error("channel results out of order");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("result changed while stalled");

    // Reset leaves no result on offer.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered after reset");

endmodule

bind rc_serial_frame_receiver rcsfr_checker u_rcsfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
